// ===== rtl/core/assert_macros.svh =====
// ============================================================================
// assert_macros.svh - assertion shorthands
// Concurrent assertion macros clocked on clk, with and without reset gating.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge while reset is low.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/mdv_pkg.sv =====
// ============================================================================
// mdv_pkg - shared definitions
// Widths, codes and the command and status bundles of the mean and variance
// block.
// ============================================================================
`default_nettype none

package mdv_pkg;

  localparam int MAX_SAMPLES = 32;
  localparam int IDX_W  = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SAMP_W = 16;
  localparam int FRAC_W = 8;
  localparam int SUM_W  = 22;
  localparam int MEAN_W = 24;
  localparam int DEV_W  = 25;
  localparam int SQ_W   = 2 * DEV_W;
  localparam int ACC_W  = 54;
  localparam int VAR_W  = 48;
  localparam int DIV_W  = ACC_W;
  localparam int STEP_W = $clog2(DIV_W + 1);

  localparam logic KIND_DEV = 1'b0;
  localparam logic KIND_SUM = 1'b1;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_sel_var;
    logic mean_take;
    logic rd;
    logic dev_take;
    logic emit_dev;
    logic mul;
    logic acc;
    logic var_take;
    logic emit_sum;
  } cmd_t;

  typedef struct packed {
    logic close;
    logic div_busy;
    logic div_done;
    logic last_idx;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/mdv_in_if.sv =====
// ============================================================================
// mdv_in_if - sample channel
// Valid/ready channel carrying one sample and its closing mark.
// ============================================================================
`default_nettype none

interface mdv_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last_sample;

  modport source (output valid, sample, last_sample, input ready);
  modport sink   (input valid, sample, last_sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mdv_out_if.sv =====
// ============================================================================
// mdv_out_if - result channel
// Valid/ready channel carrying deviation and summary results.
// ============================================================================
`default_nettype none

interface mdv_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] sample_echo;
  logic signed [24:0] deviation;
  logic signed [21:0] total;
  logic signed [23:0] mean;
  logic        [47:0] variance;
  logic               overflowed;
  logic               last_result;

  modport source (output valid, kind, sample_echo, deviation, total, mean, variance,
                  overflowed, last_result, input ready);
  modport sink   (input valid, kind, sample_echo, deviation, total, mean, variance,
                  overflowed, last_result, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mdv_ram.sv =====
// ============================================================================
// mdv_ram - generic RAM
// One write port, one read port with registered read data.
// ============================================================================
`default_nettype none

module mdv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mdv_div.sv =====
// ============================================================================
// mdv_div - serial divider
// Restoring unsigned divider, one quotient bit per cycle, small divisor.
// ============================================================================
`default_nettype none

module mdv_div import mdv_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic      [DIV_W-1:0] quotient
);

  logic [CNT_W-1:0]  rem;
  logic [STEP_W-1:0] steps;
  logic [CNT_W:0]    trial;

  assign trial = {rem, quotient[DIV_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIV_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      // The remainder stays below the divisor, so it fits the divisor width.
      if (trial >= {1'b0, divisor}) begin
        rem      <= CNT_W'(trial - {1'b0, divisor});
        quotient <= {quotient[DIV_W-2:0], 1'b1};
      end else begin
        rem      <= trial[CNT_W-1:0];
        quotient <= {quotient[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mdv_datapath.sv =====
// ============================================================================
// mdv_datapath - sample store and arithmetic
// Sample store, running sums, mean and variance division, deviation and
// squaring, and the result register.
// ============================================================================
`default_nettype none

module mdv_datapath import mdv_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cmd_t  cmd,
  output sts_t       sts,
  mdv_in_if.sink     in_ch,
  mdv_out_if.source  out_ch
);

  logic [CNT_W-1:0]         count;
  logic signed [SUM_W-1:0]  sum;
  logic [ACC_W-1:0]         acc;
  logic                     drop;
  logic [IDX_W-1:0]         idx;
  logic signed [MEAN_W-1:0] mean;
  logic signed [SAMP_W-1:0] samp;
  logic signed [DEV_W-1:0]  dev;
  logic [SQ_W-1:0]          sq;
  logic [VAR_W-1:0]         var_q;

  logic                     take;
  logic                     store_ok;
  logic [SAMP_W-1:0]        ram_rdata;
  logic [SUM_W-1:0]         sum_mag;
  logic [DIV_W-1:0]         dividend;
  logic [DIV_W-1:0]         quotient;
  logic [MEAN_W-1:0]        mean_mag;
  logic signed [DEV_W-1:0]  scaled;
  logic signed [SQ_W-1:0]   prod;

  assign in_ch.ready = cmd.load;
  assign take        = cmd.load & in_ch.valid;
  assign store_ok    = count < CNT_W'(MAX_SAMPLES);

  mdv_ram #(.WIDTH(SAMP_W), .DEPTH(MAX_SAMPLES)) u_store (
    .clk   (clk),
    .we    (take & store_ok),
    .waddr (count[IDX_W-1:0]),
    .wdata (in_ch.sample),
    .re    (cmd.rd),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign sum_mag  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign dividend = cmd.div_sel_var ? acc : DIV_W'({sum_mag, {FRAC_W{1'b0}}});

  mdv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (count),
    .busy     (sts.div_busy),
    .done     (sts.div_done),
    .quotient (quotient)
  );

  assign mean_mag = quotient[MEAN_W-1:0];
  assign scaled   = DEV_W'($signed(ram_rdata)) <<< FRAC_W;
  assign prod     = SQ_W'(dev) * SQ_W'(dev);

  assign sts.close    = take & in_ch.last_sample;
  assign sts.last_idx = {1'b0, idx} == CNT_W'(count - 1'b1);
  assign sts.out_free = !out_ch.valid || out_ch.ready;

  // Set bookkeeping: cleared by reset and when the summary is loaded into the output register.
  always_ff @(posedge clk) begin
    if (rst || cmd.emit_sum) begin
      count <= '0;
      sum   <= '0;
      acc   <= '0;
      drop  <= 1'b0;
    end else begin
      if (take) begin
        if (store_ok) begin
          count <= count + 1'b1;
          sum   <= sum + SUM_W'(in_ch.sample);
        end else begin
          drop <= 1'b1;
        end
      end
      if (cmd.acc) begin
        acc <= acc + ACC_W'(sq);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mean_take) begin
      mean <= sum[SUM_W-1] ? MEAN_W'(-mean_mag) : MEAN_W'(mean_mag);
      idx  <= '0;
    end else if (cmd.acc) begin
      idx <= idx + 1'b1;
    end
    if (cmd.dev_take) begin
      samp <= $signed(ram_rdata);
      dev  <= scaled - DEV_W'(mean);
    end
    if (cmd.mul) begin
      sq <= $unsigned(prod);
    end
    if (cmd.var_take) begin
      var_q <= quotient[VAR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (cmd.emit_dev || cmd.emit_sum) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_dev) begin
      out_ch.kind        <= KIND_DEV;
      out_ch.sample_echo <= samp;
      out_ch.deviation   <= dev;
      out_ch.total       <= '0;
      out_ch.mean        <= '0;
      out_ch.variance    <= '0;
      out_ch.overflowed  <= 1'b0;
      out_ch.last_result <= 1'b0;
    end else if (cmd.emit_sum) begin
      out_ch.kind        <= KIND_SUM;
      out_ch.sample_echo <= '0;
      out_ch.deviation   <= '0;
      out_ch.total       <= sum;
      out_ch.mean        <= mean;
      out_ch.variance    <= var_q;
      out_ch.overflowed  <= drop;
      out_ch.last_result <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mdv_ctrl.sv =====
// ============================================================================
// mdv_ctrl - sequencer
// State machine that loads samples and then steps the datapath through the
// mean, deviation and variance pass.
// ============================================================================
`default_nettype none

module mdv_ctrl import mdv_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_MSTART = 4'd1;
  localparam logic [3:0] S_MWAIT  = 4'd2;
  localparam logic [3:0] S_RD     = 4'd3;
  localparam logic [3:0] S_DEV    = 4'd4;
  localparam logic [3:0] S_EMIT   = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_ACC    = 4'd7;
  localparam logic [3:0] S_VSTART = 4'd8;
  localparam logic [3:0] S_VWAIT  = 4'd9;
  localparam logic [3:0] S_SUM    = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_LOAD: begin
        cmd.load = 1'b1;
        if (sts.close) state_next = S_MSTART;
      end
      S_MSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_MWAIT;
      end
      S_MWAIT: begin
        if (sts.div_done) begin
          cmd.mean_take = 1'b1;
          state_next    = S_RD;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_DEV;
      end
      S_DEV: begin
        cmd.dev_take = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_dev = 1'b1;
          state_next   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = sts.last_idx ? S_VSTART : S_RD;
      end
      S_VSTART: begin
        cmd.div_start   = 1'b1;
        cmd.div_sel_var = 1'b1;
        state_next      = S_VWAIT;
      end
      S_VWAIT: begin
        if (sts.div_done) begin
          cmd.var_take = 1'b1;
          state_next   = S_SUM;
        end
      end
      S_SUM: begin
        if (sts.out_free) begin
          cmd.emit_sum = 1'b1;
          state_next   = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/mean_deviation_variance.sv =====
// ============================================================================
// mean_deviation_variance - population mean and two-pass variance
// Collects a set of signed samples, then reports each sample's Q8 deviation
// from the Q8 mean and a summary with sum, mean and Q16 variance.
// ============================================================================
//
//   Channel  Direction  Transaction
//   in_ch    sink       one sample; last_sample closes the set
//   out_ch   source     one deviation per stored sample, then one summary
//
// Samples are taken one per cycle while the set is open. The closing
// transaction starts a pass over the N stored samples: two runs of the serial
// divider (mean, then variance), each a start step, 54 shift steps and a
// done step, then five steps per sample through the single store read port
// and the squarer, and a last step to load the summary.
// Output stalls lengthen the pass, since each result waits in the output register.
// Reset is synchronous and empties the set; the store itself is not cleared.
// No sample is taken during the pass.
`default_nettype none

`include "assert_macros.svh"

module mean_deviation_variance import mdv_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  mdv_in_if.sink    in_ch,
  mdv_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;

  // The sequencer owns the state; the datapath owns storage and both channels.
  mdv_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  mdv_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sts    (sts),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // A result is only loaded when the output register is free to take it.
  `ASSERT_RST(a_emit_free, (cmd.emit_dev || cmd.emit_sum) |-> sts.out_free, "result overwritten")
  // Loading samples, emitting deviations and emitting the summary are exclusive.
  `ASSERT_RST(a_cmd_excl, $onehot0({cmd.load, cmd.emit_dev, cmd.emit_sum}), "command clash")
  // The divider reports completion only at the end of a busy run.
  `ASSERT_RST(a_div_done, sts.div_done |-> $past(sts.div_busy), "divider done without run")
  // Samples are never taken while the divider works.
  `ASSERT_RST(a_load_idle, cmd.load |-> !sts.div_busy, "sample taken during division")

endmodule

`default_nettype wire

// ===== test/mdv_tb_pkg.sv =====
// ============================================================================
// mdv_tb_pkg - testbench item types
// Expected result record shared by the predictor and the result checker.
// ============================================================================
`default_nettype none

package mdv_tb_pkg;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] sample_echo;
    logic signed [24:0] deviation;
    logic signed [21:0] total;
    logic signed [23:0] mean;
    logic        [47:0] variance;
    logic               overflowed;
    logic               last_result;
  } mdv_result_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last_sample;
  } mdv_sample_t;

endpackage

`default_nettype wire

// ===== test/testbench.sv =====
// ============================================================================
// testbench - mean_deviation_variance self-checking bench
// Sends sets of samples, predicts every deviation and summary result in
// fixed point and compares each received transaction field by field.
// ============================================================================
`default_nettype none

module testbench;
  import mdv_pkg::*;
  import mdv_tb_pkg::*;

  localparam int LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mdv_in_if  in_ch ();
  mdv_out_if out_ch ();

  mean_deviation_variance dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Samples waiting to be offered, and results predicted but not yet seen.
  mdv_sample_t pending_samples[$];
  mdv_result_t expected_results[$];

  // Predictor copy of the block's set state.
  logic signed [15:0] set_store[MAX_SAMPLES];
  int unsigned        set_count;
  longint             set_sum;
  bit                 set_dropped;

  // Idling percentages, changed per phase; long_hold stalls the receiver.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          long_hold;
  int unsigned hold_cycles;

  int unsigned mismatches;
  int unsigned cycles;

  // Fold one accepted sample into the prediction; the closing sample
  // produces the deviation results followed by the summary.
  task automatic predict_set(input mdv_sample_t item);
    longint      mean_q8;
    longint      dev;
    longint      sq_acc;
    mdv_result_t r;
    begin
      if (set_count < MAX_SAMPLES) begin
        set_store[set_count] = item.sample;
        set_count++;
        set_sum += item.sample;
      end else begin
        set_dropped = 1'b1;
      end
      if (item.last_sample) begin
        mean_q8 = 0;
        if (set_count != 0) mean_q8 = (set_sum * 256) / longint'(set_count);
        sq_acc = 0;
        for (int i = 0; i < set_count; i++) begin
          dev = longint'(set_store[i]) * 256 - mean_q8;
          sq_acc = (sq_acc + dev * dev) & 64'h3F_FFFF_FFFF_FFFF;
          r = '0;
          r.kind = KIND_DEV;
          r.sample_echo = set_store[i];
          r.deviation = dev[24:0];
          expected_results = {expected_results, r};
        end
        r = '0;
        r.kind = KIND_SUM;
        r.total = set_sum[21:0];
        r.mean = mean_q8[23:0];
        if (set_count != 0) r.variance = 48'(sq_acc / longint'(set_count));
        r.overflowed = set_dropped;
        r.last_result = 1'b1;
        expected_results = {expected_results, r};
        set_count = 0;
        set_sum = 0;
        set_dropped = 1'b0;
      end
    end
  endtask

  task automatic queue_set(input int n, input bit extreme);
    mdv_sample_t s;
    int          pick;
    begin
      for (int i = 0; i < n; i++) begin
        pick = $urandom_range(0, 9);
        if (extreme || pick == 0) s.sample = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : -16'sh8000;
        else if (pick < 4) s.sample = $signed(16'($urandom_range(0, 16) - 8));
        else s.sample = $signed(16'($urandom));
        s.last_sample = (i == n - 1);
        pending_samples = {pending_samples, s};
      end
    end
  endtask

  // Driver: offers the head of the queue, holding it until it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_set(pending_samples.pop_front());
      end
      if ((!in_ch.valid || in_ch.ready) && pending_samples.size() != 0 &&
          (in_ch.valid && in_ch.ready ? pending_samples.size() > 0 : 1'b1) &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        in_ch.valid       <= 1'b1;
        in_ch.sample      <= pending_samples[0].sample;
        in_ch.last_sample <= pending_samples[0].last_sample;
      end else if (in_ch.valid && in_ch.ready) begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    mdv_result_t got;
    mdv_result_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.kind, out_ch.sample_echo, out_ch.deviation, out_ch.total,
                out_ch.mean, out_ch.variance, out_ch.overflowed, out_ch.last_result};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      out_ch.ready <= !long_hold && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Long receiver hold-off, counted in its own process.
  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      long_hold   <= 1'b1;
    end else begin
      long_hold <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("mean_deviation_variance test failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.last_sample = 1'b0;
    out_ch.ready = 1'b0;
    set_count = 0;
    set_sum = 0;
    set_dropped = 1'b0;
    mismatches = 0;
    cycles = 0;
    long_hold = 1'b0;
    hold_cycles = 0;
    send_idle_pct = 31;
    recv_idle_pct = 50;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed sets: two single-sample sets and a pair at random extremes, full
    // store, overflow drops including a dropped closing sample.
    queue_set(1, 1'b1);
    queue_set(1, 1'b1);
    queue_set(2, 1'b1);
    queue_set(MAX_SAMPLES, 1'b1);
    queue_set(MAX_SAMPLES + 3, 1'b0);
    queue_set(MAX_SAMPLES + 1, 1'b1);
    hold_cycles = 400;
    while (pending_samples.size() != 0) @(posedge clk);

    // Random sets in three idling phases.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 50 : 0;
      recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 31 : 0;
      for (int k = 0; k < 120;) begin
        int n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 12);
        queue_set(n, 1'b0);
        k += n;
      end
      while (pending_samples.size() != 0) @(posedge clk);
    end

    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("mean_deviation_variance test passed");
    end else begin
      $display("mean_deviation_variance test failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
